// ===== rtl/rbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbd_pkg
// Types and constants shared by the ring buffer deque blocks.
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam int CNT_W  = 7;
  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [DATA_W-1:0] value;
  } cmd_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
    logic              is_full;
    logic              is_empty;
  } rsp_item_t;

  // per-transaction result from the pointer logic, minus the read data
  typedef struct packed {
    status_t          status;
    logic [CNT_W-1:0] count;
    logic             is_full;
    logic             is_empty;
    logic             rd_hit;
  } res_t;

endpackage

// ===== rtl/rbd_ram.sv =====
// ----------------------------------------------------------------------------
// rbd_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module rbd_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/rbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbd_ctrl
// Head, tail, count and capacity registers; one command per cycle on acc.
// ----------------------------------------------------------------------------
module rbd_ctrl #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      acc,
  input  rbd_pkg::cmd_item_t        item,
  input  logic                      cfg_wen,
  input  logic [rbd_pkg::CNT_W-1:0] cfg_wdata,
  output logic                      mem_we,
  output logic [IDX_W-1:0]          mem_waddr,
  output logic                      mem_re,
  output logic [IDX_W-1:0]          mem_raddr,
  output rbd_pkg::res_t             res
);
  import rbd_pkg::*;

  localparam int CMP_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
  localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'((DEPTH < 127) ? DEPTH : 127);
  localparam logic [CNT_W-1:0] CAP_RST = CNT_W'((DEPTH < 64) ? DEPTH : 64);

  logic [IDX_W-1:0] head, head_next;
  logic [IDX_W-1:0] tail, tail_next;
  logic [CNT_W-1:0] entry_count, entry_count_next;
  logic [CNT_W-1:0] cap;   // effective capacity, always 1..min(DEPTH, 127)

  logic [CMP_W-1:0] cap_ext, cap_m1, head_inc, tail_inc;
  logic [IDX_W-1:0] head_nx, head_pv, tail_nx, tail_pv;
  logic             full, empty;
  status_t          status;
  logic             rd_hit;

  assign cap_ext  = CMP_W'(cap);
  assign cap_m1   = cap_ext - 1'b1;
  assign head_inc = CMP_W'(head) + 1'b1;
  assign tail_inc = CMP_W'(tail) + 1'b1;

  assign head_nx = (head_inc >= cap_ext) ? '0 : head_inc[IDX_W-1:0];
  assign tail_nx = (tail_inc >= cap_ext) ? '0 : tail_inc[IDX_W-1:0];
  assign head_pv = (head == '0) ? cap_m1[IDX_W-1:0] : head - 1'b1;
  assign tail_pv = (tail == '0) ? cap_m1[IDX_W-1:0] : tail - 1'b1;

  assign full  = entry_count >= cap;
  assign empty = entry_count == '0;

  always_comb begin
    head_next        = head;
    tail_next        = tail;
    entry_count_next = entry_count;
    status           = ST_DONE;
    rd_hit           = 1'b0;
    mem_we           = 1'b0;
    mem_waddr        = tail;
    mem_raddr        = head;
    case (item.command)
      CMD_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          mem_we           = acc;
          mem_waddr        = tail;
          tail_next        = tail_nx;
          entry_count_next = entry_count + 1'b1;
        end
      end
      CMD_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          mem_we           = acc;
          mem_waddr        = head_pv;
          head_next        = head_pv;
          entry_count_next = entry_count + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          rd_hit           = 1'b1;
          mem_raddr        = head;
          head_next        = head_nx;
          entry_count_next = entry_count - 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          rd_hit           = 1'b1;
          mem_raddr        = tail_pv;
          tail_next        = tail_pv;
          entry_count_next = entry_count - 1'b1;
        end
      end
      CMD_PEEK_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          rd_hit    = 1'b1;
          mem_raddr = head;
        end
      end
      CMD_PEEK_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          rd_hit    = 1'b1;
          mem_raddr = tail_pv;
        end
      end
      default: begin
        // undefined command: no state change, report current count
      end
    endcase
  end

  assign mem_re       = acc;
  assign res.status   = status;
  assign res.count    = entry_count_next;
  assign res.is_full  = entry_count_next == cap;
  assign res.is_empty = entry_count_next == '0;
  assign res.rd_hit   = rd_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      tail        <= '0;
      entry_count <= '0;
      cap         <= CAP_RST;
    end else if (acc) begin
      head        <= head_next;
      tail        <= tail_next;
      entry_count <= entry_count_next;
    end else if (cfg_wen && empty) begin
      // capacity only changes while empty; pointers restart at slot 0
      head <= '0;
      tail <= '0;
      if (cfg_wdata == '0) begin
        cap <= CNT_W'(1);
      end else if (cfg_wdata > CAP_MAX) begin
        cap <= CAP_MAX;
      end else begin
        cap <= cfg_wdata;
      end
    end
  end

  // tail always sits count slots past head, modulo capacity
  logic [CMP_W-1:0] ring_sum, ring_pos;
  assign ring_sum = CMP_W'(head) + CMP_W'(entry_count);
  assign ring_pos = (ring_sum >= cap_ext) ? ring_sum - cap_ext : ring_sum;

  a_ring_consistent: assert property (@(posedge clk) disable iff (rst)
    ring_pos == CMP_W'(tail))
    else $error("tail does not match head plus count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= cap)
    else $error("count exceeds capacity");

  a_cap_range: assert property (@(posedge clk) disable iff (rst)
    cap != '0 && int'(cap) <= DEPTH)
    else $error("effective capacity out of range");

  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    acc && status != ST_DONE |=> entry_count == $past(entry_count) &&
      head == $past(head) && tail == $past(tail))
    else $error("rejected transaction changed state");

endmodule

// ===== rtl/ring_buffer_deque_core.sv =====
// ----------------------------------------------------------------------------
// ring_buffer_deque_core
// Double-ended queue in a circular RAM, capacity set over cfg up to min(DEPTH, 127).
//
//   channel   direction  handshake           payload
//   cmd       in         cmd_valid/cmd_ready cmd_item_t  (command, value)
//   rsp       out        rsp_valid/rsp_ready rsp_item_t  (data, status, count,
//                                                         is_full, is_empty)
//   cfg       in         cfg_wen             cfg_wdata   (capacity)
//
// One command per cycle; its response is valid the cycle after acceptance.
// The rate is set by the single RAM read port and the registered pointer update.
// cmd_ready drops only while a response is held and rsp_ready is low.
// Reset clears pointers and count and sets capacity to min(DEPTH, 64); RAM is not cleared.
// ----------------------------------------------------------------------------
module ring_buffer_deque_core #(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  input  rbd_pkg::cmd_item_t        cmd,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output rbd_pkg::rsp_item_t        rsp,
  input  logic                      cfg_wen,
  input  logic [rbd_pkg::CNT_W-1:0] cfg_wdata
);
  import rbd_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);

  logic              acc;
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_rdata;
  res_t              res, res_q;

  assign cmd_ready = !rsp_valid || rsp_ready;
  assign acc       = cmd_valid && cmd_ready;

  rbd_ctrl #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .item      (cmd),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .res       (res)
  );

  rbd_ram #(
    .DEPTH (DEPTH),
    .WIDTH (DATA_W),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (cmd.value),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (acc) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_q <= res;
    end
  end

  // RAM read data is held with res_q, since reads only fire on acceptance
  assign rsp.data     = res_q.rd_hit ? mem_rdata : '0;
  assign rsp.status   = res_q.status;
  assign rsp.count    = res_q.count;
  assign rsp.is_full  = res_q.is_full;
  assign rsp.is_empty = res_q.is_empty;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks ring_buffer_deque_core against a cycle-free deque predictor: directed
// commands on the empty, partly filled and full queue, capacity edge values,
// then fill/drain sweeps with random words over a range of capacities, with
// random idle cycles on both the command and the response channel.
// ----------------------------------------------------------------------------
module testbench;
  import rbd_pkg::*;

  localparam int DEPTH      = 64;
  localparam int IDLE_PCT   = 26;
  localparam int WDOG_LIMIT = 2000;

  // command codes with no meaning; the block must answer with no state change
  localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cmd_valid = 1'b0;
  logic             cmd_ready;
  cmd_item_t        cmd_item  = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  rsp_item_t        rsp;
  logic             cfg_wen   = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  bit steady = 1'b0;  // no idling on either side while set
  int errors = 0;

  // predictor state
  logic [DATA_W-1:0] slots [DEPTH];
  int unsigned       q_head   = 0;
  int unsigned       q_tail   = 0;
  int unsigned       q_count  = 0;
  logic [CNT_W-1:0]  capacity = 7'd64;

  rsp_item_t deque_results_q [$];

  ring_buffer_deque_core #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd_item),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    rsp_ready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic int unsigned active_cap();
    if (capacity == 0) return 1;
    if (capacity > DEPTH) return DEPTH;
    return capacity;
  endfunction

  function automatic int unsigned wrap_next(int unsigned i, int unsigned lim);
    return (i + 1 >= lim) ? 0 : i + 1;
  endfunction

  function automatic int unsigned wrap_prev(int unsigned i, int unsigned lim);
    return (i == 0 || i >= lim) ? lim - 1 : i - 1;
  endfunction

  // applies one command to the predictor and returns the response it implies
  function automatic rsp_item_t deque_predict(cmd_item_t item);
    rsp_item_t   r;
    int unsigned lim;
    bit          full;
    bit          empty;
    lim   = active_cap();
    full  = q_count >= lim;
    empty = q_count == 0;
    r     = '0;
    r.status = ST_DONE;
    case (item.command)
      CMD_PUSH_BACK: begin
        if (full) begin
          r.status = ST_FULL;
        end else begin
          slots[q_tail] = item.value;
          q_tail = wrap_next(q_tail, lim);
          q_count++;
        end
      end
      CMD_PUSH_FRONT: begin
        if (full) begin
          r.status = ST_FULL;
        end else begin
          q_head = wrap_prev(q_head, lim);
          slots[q_head] = item.value;
          q_count++;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = slots[q_head];
          q_head = wrap_next(q_head, lim);
          q_count--;
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          r.status = ST_EMPTY;
        end else begin
          q_tail = wrap_prev(q_tail, lim);
          r.data = slots[q_tail];
          q_count--;
        end
      end
      CMD_PEEK_FRONT: begin
        if (empty) r.status = ST_EMPTY;
        else r.data = slots[q_head];
      end
      CMD_PEEK_BACK: begin
        if (empty) r.status = ST_EMPTY;
        else r.data = slots[wrap_prev(q_tail, lim)];
      end
      default: ;
    endcase
    r.count    = q_count[CNT_W-1:0];
    r.is_full  = q_count == lim;
    r.is_empty = q_count == 0;
    return r;
  endfunction

  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [DATA_W-1:0] v);
    cmd_item_t item;
    item.command = c;
    item.value   = v;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_item  <= item;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    deque_results_q.push_back(deque_predict(item));
  endtask

  // block idle: no command pending and every response drained
  task automatic wait_idle();
    cmd_valid <= 1'b0;
    while (deque_results_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] v);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    // ignored while entries are held
    if (q_count == 0) begin
      capacity = v;
      q_head   = 0;
      q_tail   = 0;
    end
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] exp_v,
                             input logic [DATA_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    rsp_item_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (deque_results_q.size() == 0) begin
        $error("response transaction with none outstanding: 0x%0h", rsp);
        errors++;
      end else begin
        want = deque_results_q.pop_front();
        check_field("data", want.data, rsp.data);
        check_field("status", DATA_W'(want.status), DATA_W'(rsp.status));
        check_field("count", DATA_W'(want.count), DATA_W'(rsp.count));
        check_field("is_full", DATA_W'(want.is_full), DATA_W'(rsp.is_full));
        check_field("is_empty", DATA_W'(want.is_empty), DATA_W'(rsp.is_empty));
      end
    end
  end

  // ends the run when no transaction moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WDOG_LIMIT) begin
      @(posedge clk);
      if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // rejects and commands without meaning on the empty queue, then both ends
  // in use with the head wrapping below slot zero
  task automatic test_directed_ops();
    send_cmd(CMD_POP_FRONT, 32'h0);
    send_cmd(CMD_POP_BACK, 32'hFFFF_FFFF);
    send_cmd(CMD_PEEK_FRONT, 32'h0);
    send_cmd(CMD_PEEK_BACK, 32'h0);
    send_cmd(CMD_UNUSED_6, 32'h1234_5678);
    send_cmd(CMD_PUSH_BACK, 32'h0000_0000);
    send_cmd(CMD_PUSH_BACK, 32'hFFFF_FFFF);
    send_cmd(CMD_PUSH_FRONT, 32'hAAAA_AAAA);
    send_cmd(CMD_PUSH_FRONT, 32'h5555_5555);
    send_cmd(CMD_PEEK_FRONT, 32'h0);
    send_cmd(CMD_PEEK_BACK, 32'h0);
    send_cmd(CMD_UNUSED_7, 32'hFFFF_FFFF);
    send_cmd(CMD_POP_FRONT, 32'h0);
    send_cmd(CMD_POP_BACK, 32'h0);
    send_cmd(CMD_POP_BACK, 32'h0);
    send_cmd(CMD_POP_FRONT, 32'h0);
  endtask

  // zero capacity acts as one and a write while not empty is dropped; a value
  // above the depth is then written while empty
  task automatic test_capacity_limits();
    wait_idle();
    write_capacity(7'd0);
    send_cmd(CMD_PUSH_BACK, 32'h8000_0001);
    send_cmd(CMD_PUSH_FRONT, 32'h7FFF_FFFE);
    wait_idle();
    write_capacity(7'd5);
    send_cmd(CMD_PUSH_BACK, 32'hDEAD_BEEF);
    send_cmd(CMD_POP_BACK, 32'h0);
    send_cmd(CMD_POP_FRONT, 32'h0);
    wait_idle();
    write_capacity(7'd127);
  endtask

  // fill/drain sweeps: push-heavy until full, pop-heavy until empty
  task automatic test_random_sessions();
    logic [CNT_W-1:0] caps [12];
    logic [CMD_W-1:0] c;
    int               r;
    int               push_pct;
    int               pop_pct;
    int               n_items;
    bit               filling;
    caps = '{7'd1, 7'd2, 7'd3, 7'd5, 7'd8, 7'd16, 7'd31, 7'd64, 7'd100, 7'd127,
             7'd0, 7'd0};
    caps[11] = CNT_W'($urandom_range(127));
    foreach (caps[i]) begin
      wait_idle();
      write_capacity(caps[i]);
      steady  = (i == 7);
      filling = 1'b1;
      n_items = 2 * active_cap() + 60;
      repeat (n_items) begin
        if (q_count >= active_cap()) filling = 1'b0;
        else if (q_count == 0) filling = 1'b1;
        push_pct = filling ? 65 : 20;
        pop_pct  = filling ? 20 : 65;
        r = $urandom_range(99);
        if (r < push_pct)
          c = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        else if (r < push_pct + pop_pct)
          c = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
        else if (r < 97)
          c = $urandom_range(1) ? CMD_PEEK_BACK : CMD_PEEK_FRONT;
        else
          c = $urandom_range(1) ? CMD_UNUSED_7 : CMD_UNUSED_6;
        send_cmd(c, $urandom);
      end
      steady = 1'b0;
      // usually dropped, since the queue tends to hold entries here
      wait_idle();
      write_capacity(CNT_W'($urandom_range(127)));
      while (q_count != 0)
        send_cmd($urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT, $urandom);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed_ops();
    test_capacity_limits();
    test_random_sessions();
    wait_idle();
    repeat (2) @(posedge clk);
    if (errors == 0 && deque_results_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rbd_pkg.sv
rtl/rbd_ram.sv
rtl/rbd_ctrl.sv
rtl/ring_buffer_deque_core.sv
dv/testbench.sv
